/* rtl/configurable_crc_engine_macros.svh */
// Assertion macros used by the CRC engine checker.
// No dependencies; take in with `include before use.
`ifndef CONFIGURABLE_CRC_ENGINE_MACROS_SVH
`define CONFIGURABLE_CRC_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CRCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crc engine check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CRCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crc engine check failed");

`endif

/* rtl/crce_pkg.sv */
// Shared types and constants for the configurable CRC engine.
// No dependencies; used by every module of the block.
package crce_pkg;

   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 5;
   localparam int REG_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [REG_IDX_W-1:0] REG_WIDTH_SEL   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GEN_POLY    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_START_VALUE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REFLECT_IN  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REFLECT_OUT = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OUTPUT_XOR  = 3'd5;

   localparam logic [1:0] WSEL_8  = 2'd0;
   localparam logic [1:0] WSEL_16 = 2'd1;

   localparam logic [1:0]  RST_WIDTH_SEL   = 2'd2;
   localparam logic [31:0] RST_GEN_POLY    = 32'h04C1_1DB7;
   localparam logic [31:0] RST_START_VALUE = 32'hFFFF_FFFF;
   localparam logic        RST_REFLECT_IN  = 1'b1;
   localparam logic        RST_REFLECT_OUT = 1'b1;
   localparam logic [31:0] RST_OUTPUT_XOR  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        load;
      logic [31:0] load_value;
      logic [7:0]  data;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [1:0]  width_sel;
      logic [31:0] gen_poly;
      logic        reflect_out;
      logic [31:0] output_xor;
   } back_cfg_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

/* rtl/crce_front.sv */
// Front end: request handshake and classification into queue items.
// Depends on crce_pkg.
module crce_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_first_byte,
   input  logic                 req_last_byte,
   input  logic                 req_use_seed,
   input  logic [31:0]          req_seed_value,
   input  logic                 reflect_in,
   input  logic [31:0]          start_value,
   input  logic                 queue_ready,
   output logic                 push,
   output crce_pkg::item_type   item
);

   assign req_ready = queue_ready;
   assign push      = req_valid && queue_ready;

   always_comb begin
      item.load       = req_first_byte;
      item.load_value = req_use_seed ? req_seed_value : start_value;
      item.data       = reflect_in ? crce_pkg::reverse8(req_data_byte) : req_data_byte;
      item.last       = req_last_byte;
   end

endmodule

/* rtl/crce_queue.sv */
// Two-entry queue decoupling the front end from the CRC datapath.
// Depends on crce_pkg.
module crce_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  crce_pkg::item_type   push_item,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output crce_pkg::item_type   pop_item
);

   crce_pkg::item_type                  slot_ff [crce_pkg::QUEUE_DEPTH];
   logic [crce_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [crce_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [crce_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign push_ready = (count_ff != crce_pkg::QCNT_W'(crce_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/crce_back.sv */
// Back end: folds bytes into the running CRC, one per cycle unless a result stalls, and finalises results.
// Depends on crce_pkg.
module crce_back #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  crce_pkg::item_type       item,
   output logic                     pop,
   input  crce_pkg::back_cfg_type   cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_crc_result
);

   localparam int W16   = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
   localparam int SH8   = MAX_WIDTH - 8;
   localparam int SH16  = MAX_WIDTH - W16;
   localparam int SH_W  = $clog2(MAX_WIDTH);

   logic [MAX_WIDTH-1:0] running_ff, running_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_crc_ff, rsp_crc_in;
   logic [SH_W-1:0]      sh;
   logic [MAX_WIDTH-1:0] mask;
   logic [MAX_WIDTH-1:0] reg_u;
   logic [MAX_WIDTH-1:0] poly_a;
   logic [MAX_WIDTH-1:0] acc;
   logic [MAX_WIDTH-1:0] rev;
   logic [MAX_WIDTH-1:0] next_reg;
   logic [MAX_WIDTH-1:0] fin;

   always_comb begin
      unique case (cfg.width_sel)
         crce_pkg::WSEL_8:  sh = SH_W'(SH8);
         crce_pkg::WSEL_16: sh = SH_W'(SH16);
         default:           sh = '0;
      endcase
   end

   // Register is aligned to the MSB so the feedback tap is always the top bit.
   always_comb begin
      mask   = {MAX_WIDTH{1'b1}} >> sh;
      reg_u  = (item.load ? item.load_value[MAX_WIDTH-1:0] : running_ff) & mask;
      poly_a = (cfg.gen_poly[MAX_WIDTH-1:0] & mask) << sh;
      acc    = (reg_u << sh) ^ (MAX_WIDTH'(item.data) << SH8);
      for (int k = 0; k < 8; k++) begin
         acc = acc[MAX_WIDTH-1] ? ((acc << 1) ^ poly_a) : (acc << 1);
      end
      next_reg = acc >> sh;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         rev[i] = acc[MAX_WIDTH-1-i];
      end
      fin = ((cfg.reflect_out ? rev : next_reg) ^ cfg.output_xor[MAX_WIDTH-1:0]) & mask;
   end

   assign pop = item_valid && (!item.last || !rsp_valid_ff || rsp_ready);

   always_comb begin
      running_in   = pop ? next_reg : running_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop && item.last) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = 32'(fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_crc_ff;

endmodule

/* rtl/configurable_crc_engine.sv */
// Configurable CRC engine: one message byte per cycle when not stalled, 8/16/32-bit CRC.
// A last-byte request is stored in the queue, then folded into the registered result.
// Throughput: one request per cycle while no result is stalled, set by the combinational eight-step fold.
// Reset (synchronous, active high) restores the register defaults, clears the
// running CRC to zero and empties the queue and the result register.
module configurable_crc_engine #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_first_byte,
   input  logic                            req_last_byte,
   input  logic                            req_use_seed,
   input  logic [31:0]                     req_seed_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_crc_result,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [crce_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [crce_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [crce_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready
);

   logic [1:0]                      width_sel_ff;
   logic [31:0]                     gen_poly_ff;
   logic [31:0]                     start_value_ff;
   logic                            reflect_in_ff;
   logic                            reflect_out_ff;
   logic [31:0]                     output_xor_ff;
   logic                            csr_wr;
   logic [crce_pkg::REG_IDX_W-1:0]  reg_idx;

   crce_pkg::item_type      front_item;
   crce_pkg::item_type      back_item;
   crce_pkg::back_cfg_type  back_cfg;
   logic                    push;
   logic                    queue_ready;
   logic                    pop;
   logic                    item_valid;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[crce_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_sel_ff   <= crce_pkg::RST_WIDTH_SEL;
         gen_poly_ff    <= crce_pkg::RST_GEN_POLY;
         start_value_ff <= crce_pkg::RST_START_VALUE;
         reflect_in_ff  <= crce_pkg::RST_REFLECT_IN;
         reflect_out_ff <= crce_pkg::RST_REFLECT_OUT;
         output_xor_ff  <= crce_pkg::RST_OUTPUT_XOR;
      end else if (csr_wr) begin
         unique case (reg_idx)
            crce_pkg::REG_WIDTH_SEL:   width_sel_ff   <= csr_pwdata[1:0];
            crce_pkg::REG_GEN_POLY:    gen_poly_ff    <= csr_pwdata;
            crce_pkg::REG_START_VALUE: start_value_ff <= csr_pwdata;
            crce_pkg::REG_REFLECT_IN:  reflect_in_ff  <= csr_pwdata[0];
            crce_pkg::REG_REFLECT_OUT: reflect_out_ff <= csr_pwdata[0];
            crce_pkg::REG_OUTPUT_XOR:  output_xor_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         crce_pkg::REG_WIDTH_SEL:   csr_prdata = 32'(width_sel_ff);
         crce_pkg::REG_GEN_POLY:    csr_prdata = gen_poly_ff;
         crce_pkg::REG_START_VALUE: csr_prdata = start_value_ff;
         crce_pkg::REG_REFLECT_IN:  csr_prdata = 32'(reflect_in_ff);
         crce_pkg::REG_REFLECT_OUT: csr_prdata = 32'(reflect_out_ff);
         crce_pkg::REG_OUTPUT_XOR:  csr_prdata = output_xor_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   always_comb begin
      back_cfg.width_sel   = width_sel_ff;
      back_cfg.gen_poly    = gen_poly_ff;
      back_cfg.reflect_out = reflect_out_ff;
      back_cfg.output_xor  = output_xor_ff;
   end

   crce_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_use_seed   (req_use_seed),
      .req_seed_value (req_seed_value),
      .reflect_in     (reflect_in_ff),
      .start_value    (start_value_ff),
      .queue_ready    (queue_ready),
      .push           (push),
      .item           (front_item)
   );

   crce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (item_valid),
      .pop_item   (back_item)
   );

   crce_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (back_item),
      .pop            (pop),
      .cfg            (back_cfg),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_result (rsp_crc_result)
   );

endmodule

/* rtl/crce_checker.sv */
// Port-level checker for the CRC engine, bound to the top level.
// Depends on configurable_crc_engine_macros.svh.
`include "configurable_crc_engine_macros.svh"

module crce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_crc_result
);

   logic [2:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;
   logic       rsp_stall;
   logic       lat_start;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign lat_start = req_acc && req_last_byte && (pend_ff == 3'd0);

   // last-byte requests not yet answered
   always_comb begin
      pend_in = pend_ff + 3'(req_acc && req_last_byte) - 3'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `CRCE_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `CRCE_ASSERT_IMPL(a_no_spurious_rsp, clock, reset, rsp_valid, pend_ff != 3'd0)
   `CRCE_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_crc_result))
   `CRCE_ASSERT_IMPL(a_rsp_latency, clock, reset, lat_start && !$past(req_acc), ##2 rsp_valid)

endmodule

bind configurable_crc_engine crce_checker u_crce_checker (.*);
